### src/bgd_pkg.sv
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types and constants for the button gesture detector: the
// configuration register set, its indexes and reset values, and the
// per-sample result record.
// ----------------------------------------------------------------------------
package bgd_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_ADDR_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  // Register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_PRESSED_LEVEL = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CLICK_MAX_MS  = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SETTLE_MS     = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_HOLD_MS       = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_STREAK_GAP_MS = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_STREAK_COUNT  = 3'd5;

  // Register reset values
  localparam logic        RST_PRESSED_LEVEL = 1'b0;
  localparam logic [15:0] RST_CLICK_MAX_MS  = 16'd500;
  localparam logic [15:0] RST_SETTLE_MS     = 16'd0;
  localparam logic [15:0] RST_HOLD_MS       = 16'd1000;
  localparam logic [15:0] RST_STREAK_GAP_MS = 16'd400;
  localparam logic [7:0]  RST_STREAK_COUNT  = 8'd2;

  // Configuration register set
  typedef struct packed {
    logic        pressed_level;
    logic [15:0] click_max_ms;
    logic [15:0] settle_ms;
    logic [15:0] hold_ms;
    logic [15:0] streak_gap_ms;
    logic [7:0]  streak_count;
  } cfg_t;

  // One result per sample
  typedef struct packed {
    logic        pressed;
    logic        press_edge;
    logic        release_edge;
    logic        click;
    logic        held;
    logic [31:0] press_ms;
    logic        streak_press_done;
    logic        streak_release_done;
    logic        streak_click_done;
  } result_t;

endpackage

### src/bgd_step.sv
// ----------------------------------------------------------------------------
// bgd_step
// Combinational per-sample update: derives edges, timestamps, streak
// counters and the result record from the current state and one sample.
// ----------------------------------------------------------------------------
module bgd_step #(
  parameter int unsigned TIME_BITS   = 32,
  parameter int unsigned STREAK_BITS = 8
) (
  input  bgd_pkg::cfg_t           cfg,
  input  logic                    raw_level,
  input  logic                    level_now,
  input  logic [TIME_BITS-1:0]    tick_time,
  input  logic [TIME_BITS-1:0]    press_time,
  input  logic [TIME_BITS-1:0]    prev_press_time,
  input  logic [TIME_BITS-1:0]    release_time,
  input  logic [TIME_BITS-1:0]    prev_release_time,
  input  logic [STREAK_BITS-1:0]  press_streak,
  input  logic [STREAK_BITS-1:0]  release_streak,
  input  logic [STREAK_BITS-1:0]  click_streak,
  output logic                    level_now_next,
  output logic [TIME_BITS-1:0]    tick_time_next,
  output logic [TIME_BITS-1:0]    press_time_next,
  output logic [TIME_BITS-1:0]    prev_press_time_next,
  output logic [TIME_BITS-1:0]    release_time_next,
  output logic [TIME_BITS-1:0]    prev_release_time_next,
  output logic [STREAK_BITS-1:0]  press_streak_next,
  output logic [STREAK_BITS-1:0]  release_streak_next,
  output logic [STREAK_BITS-1:0]  click_streak_next,
  output bgd_pkg::result_t        res
);

  localparam int unsigned CMP_BITS = (STREAK_BITS > 8) ? STREAK_BITS : 8;
  localparam int unsigned PMS_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam logic [STREAK_BITS-1:0] S_MAX = {STREAK_BITS{1'b1}};
  localparam logic [STREAK_BITS-1:0] S_ONE = STREAK_BITS'(1);

  logic                   now, pe, re;
  logic [TIME_BITS-1:0]   gap, settle, hold, click_max;
  logic [TIME_BITS-1:0]   press_gap, release_gap, click_gap;
  logic [TIME_BITS-1:0]   since_press, since_release, press_len;
  logic [PMS_BITS-1:0]    since_press_ext;
  logic [CMP_BITS-1:0]    count_ext;
  logic [STREAK_BITS-1:0] ps_upd, rs_upd, cs_upd;
  logic                   short_press, settled;
  logic                   press_end, release_end, click_end;

  // Saturating streak increment
  function automatic logic [STREAK_BITS-1:0] bump(input logic [STREAK_BITS-1:0] s);
    bump = (s == S_MAX) ? S_MAX : s + S_ONE;
  endfunction

  always_comb begin
    gap       = TIME_BITS'(cfg.streak_gap_ms);
    settle    = TIME_BITS'(cfg.settle_ms);
    hold      = TIME_BITS'(cfg.hold_ms);
    click_max = TIME_BITS'(cfg.click_max_ms);
    count_ext = CMP_BITS'(cfg.streak_count);

    // Level and edges
    now = (raw_level == cfg.pressed_level);
    pe  = now && !level_now;
    re  = !now && level_now;

    // Gaps measured against the stored timestamps
    press_gap   = tick_time - press_time;
    release_gap = tick_time - release_time;
    click_gap   = press_time - release_time;

    // Timestamp updates
    press_time_next        = pe ? tick_time : press_time;
    prev_press_time_next   = pe ? press_time : prev_press_time;
    release_time_next      = re ? tick_time : release_time;
    prev_release_time_next = re ? release_time : prev_release_time;

    since_press   = pe ? '0 : press_gap;
    since_release = re ? '0 : release_gap;
    press_len     = release_time_next - press_time_next;
    short_press   = press_len < click_max;
    settled       = since_release >= settle;

    // Streak counts on edges
    ps_upd = press_streak;
    if (pe) begin
      ps_upd = (press_streak == '0 || press_gap > gap) ? S_ONE : bump(press_streak);
    end
    rs_upd = release_streak;
    if (re) begin
      rs_upd = (release_streak == '0 || release_gap > gap) ? S_ONE : bump(release_streak);
    end
    cs_upd = click_streak;
    if (re) begin
      if (!short_press) begin
        cs_upd = '0;
      end else if (click_streak == '0 || click_gap > gap) begin
        cs_upd = S_ONE;
      end else begin
        cs_upd = bump(click_streak);
      end
    end

    // Streak ends after the gap timeout
    press_end   = !pe && ps_upd != '0 && since_press > gap;
    release_end = !re && rs_upd != '0 && since_release > gap;
    click_end   = !now && !re && cs_upd != '0 && since_release > gap && settled;

    press_streak_next   = press_end ? '0 : ps_upd;
    release_streak_next = release_end ? '0 : rs_upd;
    click_streak_next   = click_end ? '0 : cs_upd;

    level_now_next = now;
    tick_time_next = tick_time + TIME_BITS'(1);

    // Result record
    since_press_ext = PMS_BITS'(since_press);
    res.pressed             = now;
    res.press_edge          = pe;
    res.release_edge        = re;
    res.click               = !now && short_press && settled;
    res.held                = now && since_press > hold;
    res.press_ms            = since_press_ext[31:0];
    res.streak_press_done   = press_end && (CMP_BITS'(ps_upd) == count_ext);
    res.streak_release_done = release_end && (CMP_BITS'(rs_upd) >= count_ext);
    res.streak_click_done   = click_end && (CMP_BITS'(cs_upd) >= count_ext);
  end

endmodule

### src/button_gesture_detector_core.sv
// ----------------------------------------------------------------------------
// button_gesture_detector_core
// Button click, double click and hold detector: one raw sample per tick in,
// one result record per sample out.
// ----------------------------------------------------------------------------
// Accepts one button sample per clock while the output is not stalled and
// returns one result per sample. A sample is held in an input register, then
// the whole state update (edge detect, timestamps, streak counters, threshold
// compares) runs combinationally into the output register, so the rate is set
// by that single state-update loop: one sample per cycle sustained while the
// output is not stalled. The user is to write configuration registers through
// the plain write port only while no samples are in flight; the block itself
// does not enforce this. Indexes above the last register are ignored.
module button_gesture_detector_core #(
  parameter int unsigned TIME_BITS   = 32,
  parameter int unsigned STREAK_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port
  input  logic                              cfg_wr_en,
  input  logic [bgd_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [bgd_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  // Sample channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              raw_level,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              pressed,
  output logic                              press_edge,
  output logic                              release_edge,
  output logic                              click,
  output logic                              held,
  output logic [31:0]                       press_ms,
  output logic                              streak_press_done,
  output logic                              streak_release_done,
  output logic                              streak_click_done
);

  bgd_pkg::cfg_t    cfg;
  bgd_pkg::result_t res_next;
  bgd_pkg::result_t res;

  logic                   in_reg_valid;
  logic                   in_reg_level;
  logic                   advance;

  logic                   level_now, level_now_next;
  logic [TIME_BITS-1:0]   tick_time, tick_time_next;
  logic [TIME_BITS-1:0]   press_time, press_time_next;
  logic [TIME_BITS-1:0]   prev_press_time, prev_press_time_next;
  logic [TIME_BITS-1:0]   release_time, release_time_next;
  logic [TIME_BITS-1:0]   prev_release_time, prev_release_time_next;
  logic [STREAK_BITS-1:0] press_streak, press_streak_next;
  logic [STREAK_BITS-1:0] release_streak, release_streak_next;
  logic [STREAK_BITS-1:0] click_streak, click_streak_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pressed_level <= bgd_pkg::RST_PRESSED_LEVEL;
      cfg.click_max_ms  <= bgd_pkg::RST_CLICK_MAX_MS;
      cfg.settle_ms     <= bgd_pkg::RST_SETTLE_MS;
      cfg.hold_ms       <= bgd_pkg::RST_HOLD_MS;
      cfg.streak_gap_ms <= bgd_pkg::RST_STREAK_GAP_MS;
      cfg.streak_count  <= bgd_pkg::RST_STREAK_COUNT;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        bgd_pkg::REG_PRESSED_LEVEL: cfg.pressed_level <= cfg_wdata[0];
        bgd_pkg::REG_CLICK_MAX_MS:  cfg.click_max_ms  <= cfg_wdata;
        bgd_pkg::REG_SETTLE_MS:     cfg.settle_ms     <= cfg_wdata;
        bgd_pkg::REG_HOLD_MS:       cfg.hold_ms       <= cfg_wdata;
        bgd_pkg::REG_STREAK_GAP_MS: cfg.streak_gap_ms <= cfg_wdata;
        bgd_pkg::REG_STREAK_COUNT:  cfg.streak_count  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Flow control: input register moves to output register when it is free
  assign advance  = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_level <= raw_level;
    end
  end

  // Per-sample update
  bgd_step #(
    .TIME_BITS   (TIME_BITS),
    .STREAK_BITS (STREAK_BITS)
  ) u_step (
    .cfg                    (cfg),
    .raw_level              (in_reg_level),
    .level_now              (level_now),
    .tick_time              (tick_time),
    .press_time             (press_time),
    .prev_press_time        (prev_press_time),
    .release_time           (release_time),
    .prev_release_time      (prev_release_time),
    .press_streak           (press_streak),
    .release_streak         (release_streak),
    .click_streak           (click_streak),
    .level_now_next         (level_now_next),
    .tick_time_next         (tick_time_next),
    .press_time_next        (press_time_next),
    .prev_press_time_next   (prev_press_time_next),
    .release_time_next      (release_time_next),
    .prev_release_time_next (prev_release_time_next),
    .press_streak_next      (press_streak_next),
    .release_streak_next    (release_streak_next),
    .click_streak_next      (click_streak_next),
    .res                    (res_next)
  );

  // Detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      level_now         <= 1'b0;
      tick_time         <= '0;
      press_time        <= '0;
      prev_press_time   <= '0;
      release_time      <= '0;
      prev_release_time <= '0;
      press_streak      <= '0;
      release_streak    <= '0;
      click_streak      <= '0;
    end else if (advance) begin
      level_now         <= level_now_next;
      tick_time         <= tick_time_next;
      press_time        <= press_time_next;
      prev_press_time   <= prev_press_time_next;
      release_time      <= release_time_next;
      prev_release_time <= prev_release_time_next;
      press_streak      <= press_streak_next;
      release_streak    <= release_streak_next;
      click_streak      <= click_streak_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign pressed             = res.pressed;
  assign press_edge          = res.press_edge;
  assign release_edge        = res.release_edge;
  assign click               = res.click;
  assign held                = res.held;
  assign press_ms            = res.press_ms;
  assign streak_press_done   = res.streak_press_done;
  assign streak_release_done = res.streak_release_done;
  assign streak_click_done   = res.streak_click_done;

endmodule

### src/bgd_checker.sv
// ----------------------------------------------------------------------------
// bgd_checker
// Port-level checks for the button gesture detector, bound to the top level.
// ----------------------------------------------------------------------------
module bgd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        pressed,
  input logic        press_edge,
  input logic        release_edge,
  input logic        click,
  input logic        held,
  input logic [31:0] press_ms
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(press_ms) && $stable(pressed))
    else $error("stalled result changed");

  // Edges are exclusive and agree with the level
  a_edge_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(press_edge && release_edge) && (!press_edge || pressed) &&
                  (!release_edge || !pressed))
    else $error("edge flags disagree with level");

  // A press edge restarts the press timer
  a_press_restart: assert property (@(posedge clk) disable iff (rst)
    out_valid && press_edge |-> press_ms == 32'd0)
    else $error("press timer not cleared on press edge");

  // Held and click need opposite levels
  a_held_click: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!held || pressed) && (!click || !pressed))
    else $error("held or click on wrong level");

endmodule

bind button_gesture_detector_core bgd_checker u_bgd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .pressed      (pressed),
  .press_edge   (press_edge),
  .release_edge (release_edge),
  .click        (click),
  .held         (held),
  .press_ms     (press_ms)
);
